FILE: rtl/radial_distortion_pixel_remap_defines.svh
// Assertion macros for the radial distortion remap block.
// Used by the checker; depends on nothing else.
`ifndef RADIAL_DISTORTION_PIXEL_REMAP_DEFINES_SVH
`define RADIAL_DISTORTION_PIXEL_REMAP_DEFINES_SVH

`define RDPR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("rdpr check failed");

`define RDPR_ASSERT_NEXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error("rdpr check failed");

`endif

FILE: rtl/rdpr_pkg.sv
// Shared types and constants for the radial distortion remap block.
// No dependencies.
package rdpr_pkg;

  localparam int unsigned CoordW  = 11;
  localparam int unsigned SideW   = 12;
  localparam int unsigned K1W     = 23;
  localparam int unsigned K2W     = 22;
  localparam int unsigned CfgW    = 23;
  localparam int unsigned OffW    = 13;
  localparam int unsigned R2W     = 24;
  localparam int unsigned RadW    = 20;
  localparam int unsigned VW      = 2 * RadW;
  localparam int unsigned RemW    = RadW + 2;
  localparam int unsigned GainW   = 48;

  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_K1     = 2'd2,
    CFG_K2     = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [VW-1:0]   v;
    logic [RemW-1:0] rem;
    logic [RadW-1:0] root;
  } sqrt_t;

  typedef struct packed {
    logic signed [OffW-1:0] ex;
    logic signed [OffW-1:0] ey;
    logic                   src_ok;
  } geo_t;

endpackage

FILE: rtl/rdpr_sqrt_cell.sv
// One cell of the square-root chain: retires one root bit per cycle while en_i is high.
// Depends on rdpr_pkg.
module rdpr_sqrt_cell (
  input  logic           clk_i,
  input  logic           en_i,
  input  rdpr_pkg::sqrt_t state_i,
  output rdpr_pkg::sqrt_t state_o
);
  import rdpr_pkg::*;

  logic [RemW+1:0] rem_ext;
  logic [RemW+1:0] trial;
  sqrt_t state_d, state_q;

  always_comb begin
    rem_ext = {state_i.rem, state_i.v[VW-1 -: 2]};
    trial   = {2'b00, state_i.root, 2'b01};
    state_d.v = state_i.v << 2;
    if (rem_ext >= trial) begin
      state_d.rem  = RemW'(rem_ext - trial);
      state_d.root = {state_i.root[RadW-2:0], 1'b1};
    end else begin
      state_d.rem  = rem_ext[RemW-1:0];
      state_d.root = {state_i.root[RadW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      state_q <= state_d;
    end
  end

  assign state_o = state_q;
endmodule

FILE: rtl/radial_distortion_pixel_remap.sv
// Top level of the radial distortion remap block.
// Depends on rdpr_pkg and rdpr_sqrt_cell.
// Takes one pixel per clock while the output is not stalled and returns one transaction per pixel;
// the pipeline is the 20-cell square-root chain plus seven arithmetic stages.
// Stall on the output holds the whole pipeline.
module radial_distortion_pixel_remap #(
  parameter int unsigned MAX_SIDE   = 2048,
  parameter int unsigned PIXEL_BITS = 24
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_index_i,
  input  logic [rdpr_pkg::CfgW-1:0]   cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [rdpr_pkg::CoordW-1:0] src_col_i,
  input  logic [rdpr_pkg::CoordW-1:0] src_row_i,
  input  logic [PIXEL_BITS-1:0]       pixel_value_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [rdpr_pkg::CoordW-1:0] dst_col_o,
  output logic [rdpr_pkg::CoordW-1:0] dst_row_o,
  output logic [PIXEL_BITS-1:0]       out_pixel_o,
  output logic                        write_enable_o
);
  import rdpr_pkg::*;

  localparam int unsigned Lat    = RadW + 7;
  localparam int unsigned SqBase = 2;
  localparam int unsigned StC    = SqBase + RadW - 1;

  logic [SideW-1:0]    width_q, height_q;
  logic signed [K1W-1:0] k1_q;
  logic signed [K2W-1:0] k2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SideW'(2048);
      height_q <= SideW'(2048);
      k1_q     <= '0;
      k2_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_WIDTH:  width_q  <= cfg_data_i[SideW-1:0];
        CFG_HEIGHT: height_q <= cfg_data_i[SideW-1:0];
        CFG_K1:     k1_q     <= cfg_data_i[K1W-1:0];
        CFG_K2:     k2_q     <= cfg_data_i[K2W-1:0];
        default: ;
      endcase
    end
  end

  logic [SideW-1:0]  w_eff, h_eff;
  logic [CoordW-1:0] cx, cy;
  assign w_eff = ({20'd0, width_q} > MAX_SIDE) ? SideW'(MAX_SIDE) : width_q;
  assign h_eff = ({20'd0, height_q} > MAX_SIDE) ? SideW'(MAX_SIDE) : height_q;
  assign cx = w_eff[SideW-1:1];
  assign cy = h_eff[SideW-1:1];

  logic en;
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  logic [Lat-1:0]        vld_q;
  geo_t                  geo_q [Lat];
  logic [PIXEL_BITS-1:0] pix_q [Lat];
  geo_t                  geo_d;

  always_comb begin
    geo_d.ex     = $signed({2'b00, src_col_i}) - $signed({2'b00, cx});
    geo_d.ey     = $signed({2'b00, src_row_i}) - $signed({2'b00, cy});
    geo_d.src_ok = ({1'b0, src_col_i} < w_eff) && ({1'b0, src_row_i} < h_eff);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      geo_q[0] <= geo_d;
      pix_q[0] <= pixel_value_i;
      for (int i = 1; i < Lat; i++) begin
        geo_q[i] <= geo_q[i-1];
        pix_q[i] <= pix_q[i-1];
      end
    end
  end

  logic signed [2*OffW-1:0] sq_x, sq_y;
  logic [R2W-1:0]           r2_q;
  assign sq_x = geo_q[0].ex * geo_q[0].ex;
  assign sq_y = geo_q[0].ey * geo_q[0].ey;

  always_ff @(posedge clk_i) begin
    if (en) begin
      r2_q <= R2W'(sq_x) + R2W'(sq_y);
    end
  end

  sqrt_t chain [RadW+1];
  assign chain[0].v    = {r2_q, 16'd0};
  assign chain[0].rem  = '0;
  assign chain[0].root = '0;

  for (genvar g = 0; g < RadW; g++) begin : g_cell
    rdpr_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .en_i    (en),
      .state_i (chain[g]),
      .state_o (chain[g+1])
    );
  end

  logic [RadW-1:0] rad;
  assign rad = chain[RadW].root;

  logic [VW-1:0]                rr_q;
  logic signed [K1W+RadW:0]     k1r_q, k1r_d_q;
  logic signed [K2W+RadW:0]     plo_q, phi_q;
  logic signed [GainW-1:0]      f32_q;
  logic signed [63:0]           f48;

  always_ff @(posedge clk_i) begin
    if (en) begin
      rr_q    <= rad * rad;
      k1r_q   <= k1_q * $signed({1'b0, rad});
      plo_q   <= k2_q * $signed({1'b0, rr_q[RadW-1:0]});
      phi_q   <= k2_q * $signed({1'b0, rr_q[VW-1:RadW]});
      k1r_d_q <= k1r_q;
      f32_q   <= GainW'(f48 >>> 16);
    end
  end

  assign f48 = (64'(phi_q) <<< RadW) + 64'(plo_q) + (64'(k1r_d_q) <<< 8)
             + (64'sd1 <<< 48);

  logic signed [OffW+24:0] mxl_q, myl_q;
  logic signed [OffW+23:0] mxh_q, myh_q;
  geo_t                    gf;
  assign gf = geo_q[StC+3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      mxl_q <= gf.ex * $signed({1'b0, f32_q[23:0]});
      myl_q <= gf.ey * $signed({1'b0, f32_q[23:0]});
      mxh_q <= gf.ex * $signed(f32_q[GainW-1:24]);
      myh_q <= gf.ey * $signed(f32_q[GainW-1:24]);
    end
  end

  logic signed [63:0] px, py;
  logic signed [31:0] tx, ty;
  logic               ok;
  geo_t               gg;
  assign gg = geo_q[StC+4];
  assign px = (64'(mxh_q) <<< 24) + 64'(mxl_q);
  assign py = (64'(myh_q) <<< 24) + 64'(myl_q);
  assign tx = $signed({21'd0, cx}) + 32'(px >>> 32);
  assign ty = $signed({21'd0, cy}) + 32'(py >>> 32);
  assign ok = gg.src_ok && (tx >= 0) && (ty >= 0)
           && (tx < $signed({20'd0, w_eff})) && (ty < $signed({20'd0, h_eff}));

  logic [CoordW-1:0]     dcol_q, drow_q;
  logic [PIXEL_BITS-1:0] opix_q;
  logic                  we_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dcol_q <= ok ? tx[CoordW-1:0] : '0;
      drow_q <= ok ? ty[CoordW-1:0] : '0;
      we_q   <= ok;
      opix_q <= pix_q[StC+4];
    end
  end

  assign out_valid_o    = vld_q[Lat-1];
  assign dst_col_o      = dcol_q;
  assign dst_row_o      = drow_q;
  assign out_pixel_o    = opix_q;
  assign write_enable_o = we_q;
endmodule

FILE: rtl/rdpr_checker.sv
// Port-level checks for the radial distortion remap block, bound to its top level.
// Depends on rdpr_pkg and radial_distortion_pixel_remap_defines.svh.
`include "radial_distortion_pixel_remap_defines.svh"
module rdpr_checker #(
  parameter int unsigned PIXEL_BITS = 24
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [rdpr_pkg::CoordW-1:0] dst_col_o,
  input logic [rdpr_pkg::CoordW-1:0] dst_row_o,
  input logic [PIXEL_BITS-1:0]       out_pixel_o,
  input logic                        write_enable_o
);
  `RDPR_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)
  `RDPR_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i, $stable(out_pixel_o) && $stable(dst_col_o))
  `RDPR_ASSERT(a_stall_cause, in_stall_o |-> (out_valid_o && out_stall_i))
  `RDPR_ASSERT(a_drop_zero, (out_valid_o && !write_enable_o) |-> (dst_col_o == 0 && dst_row_o == 0))
endmodule

bind radial_distortion_pixel_remap rdpr_checker #(.PIXEL_BITS(PIXEL_BITS)) u_rdpr_checker (.*);

FILE: tb/sv/radial_distortion_pixel_remap_test.sv
// Self-checking testbench for radial_distortion_pixel_remap: random and directed pixels
// with randomized handshake gaps, compared against a built-in remap predictor.
// Depends on rdpr_pkg and the RTL top level.
module radial_distortion_pixel_remap_test;
  timeunit 1ns;
  timeprecision 1ps;
  import rdpr_pkg::*;

  typedef struct {
    logic [10:0] col;
    logic [10:0] row;
    logic [23:0] pix;
  } pixel_t;

  typedef struct {
    logic [10:0] col;
    logic [10:0] row;
    logic [23:0] pix;
    logic        we;
  } remap_t;

  localparam int LatencyCycles = 27;
  localparam longint CycleLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_index_i = '0;
  logic [CfgW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [10:0] src_col_i = '0;
  logic [10:0] src_row_i = '0;
  logic [23:0] pixel_value_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [10:0] dst_col_o;
  logic [10:0] dst_row_o;
  logic [23:0] out_pixel_o;
  logic write_enable_o;

  radial_distortion_pixel_remap u_top (.*);

  always #5 clk_i = ~clk_i;

  logic [11:0] img_w = 12'd2048;
  logic [11:0] img_h = 12'd2048;
  logic [22:0] k1_reg = '0;
  logic [21:0] k2_reg = '0;

  pixel_t pending_pixels[$];
  remap_t expected_remaps[$];
  int errors = 0;
  longint cycles = 0;
  int send_gap = 0;
  int recv_gap = 0;
  logic in_taken = 1'b0;

  function automatic longint floor_div(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint root_floor(longint v);
    longint lo, hi, mid;
    lo = 0;
    hi = 64'd1 << 22;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (mid * mid <= v) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic remap_t predict_remap(pixel_t p);
    remap_t res;
    longint w, h, cx, cy, ex, ey, r, k1, k2, f48, f32, tx, ty;
    logic ok;
    w = (img_w > 2048) ? 2048 : img_w;
    h = (img_h > 2048) ? 2048 : img_h;
    cx = w / 2;
    cy = h / 2;
    ex = longint'(p.col) - cx;
    ey = longint'(p.row) - cy;
    r = root_floor((ex * ex + ey * ey) <<< 16);
    k1 = longint'($signed(k1_reg));
    k2 = longint'($signed(k2_reg));
    f48 = k2 * (r * r) + k1 * r * 256 + (64'sd1 <<< 48);
    f32 = floor_div(f48, 16);
    tx = cx + floor_div(ex * f32, 32);
    ty = cy + floor_div(ey * f32, 32);
    ok = (p.col < w) && (p.row < h) && tx >= 0 && tx < w && ty >= 0 && ty < h;
    res.col = ok ? tx[10:0] : '0;
    res.row = ok ? ty[10:0] : '0;
    res.pix = p.pix;
    res.we = ok;
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val[CfgW-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_WIDTH: img_w = val[11:0];
      CFG_HEIGHT: img_h = val[11:0];
      CFG_K1: k1_reg = val[22:0];
      default: k2_reg = val[21:0];
    endcase
  endtask

  task automatic wait_drained();
    while (pending_pixels.size() != 0 || in_valid_i || expected_remaps.size() != 0)
      @(negedge clk_i);
    repeat (LatencyCycles + 5) @(negedge clk_i);
  endtask

  task automatic push_pixel(int col, int row, int pix);
    pixel_t p;
    p.col = col[10:0];
    p.row = row[10:0];
    p.pix = pix[23:0];
    pending_pixels.push_back(p);
  endtask

  // drive: advance on acceptance, hold otherwise
  always @(negedge clk_i) begin
    pixel_t p;
    if (rst_ni) begin
      if (in_taken) begin
        expected_remaps.push_back(predict_remap('{src_col_i, src_row_i, pixel_value_i}));
        send_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
      end
      if (!in_valid_i || in_taken) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_pixels.size() != 0) begin
          p = pending_pixels.pop_front();
          src_col_i <= p.col;
          src_row_i <= p.row;
          pixel_value_i <= p.pix;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (recv_gap > 0) begin
      recv_gap--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    in_taken = rst_ni && in_valid_i && !in_stall_o;
    if (out_valid_o && !out_stall_i && rst_ni) begin
      if (expected_remaps.size() == 0) begin
        report_mismatch("unexpected transaction", 1, 0);
      end else begin
        remap_t e;
        e = expected_remaps.pop_front();
        if (dst_col_o !== e.col) report_mismatch("dst_col", dst_col_o, e.col);
        if (dst_row_o !== e.row) report_mismatch("dst_row", dst_row_o, e.row);
        if (out_pixel_o !== e.pix) report_mismatch("out_pixel", out_pixel_o, e.pix);
        if (write_enable_o !== e.we) report_mismatch("write_enable", write_enable_o, e.we);
      end
      recv_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
    end
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic random_phase(int n, int w, int h);
    repeat (n) begin
      if ($urandom_range(0, 9) < 8)
        push_pixel($urandom_range(0, (w > 2048 ? 2048 : w) - 1),
                   $urandom_range(0, (h > 2048 ? 2048 : h) - 1), $urandom());
      else
        push_pixel($urandom_range(0, 2047), $urandom_range(0, 2047), $urandom());
    end
    wait_drained();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    push_pixel(0, 0, 0);
    push_pixel(2047, 2047, 24'hFFFFFF);
    push_pixel(1024, 1024, 24'h5A5A5A);
    push_pixel(0, 2047, 24'hA5A5A5);
    push_pixel(2047, 0, 24'h123456);
    wait_drained();
    write_reg(CFG_WIDTH, 640);
    write_reg(CFG_HEIGHT, 480);
    write_reg(CFG_K1, 23'sd2576980);
    write_reg(CFG_K2, 22'sd1288490);
    push_pixel(0, 0, 1);
    push_pixel(639, 479, 2);
    push_pixel(640, 10, 3);
    push_pixel(10, 480, 4);
    push_pixel(320, 240, 5);
    wait_drained();
    write_reg(CFG_K1, -23'sd2576980);
    write_reg(CFG_K2, -22'sd1288490);
    push_pixel(0, 0, 6);
    push_pixel(639, 0, 7);
    push_pixel(319, 479, 8);
    wait_drained();
    write_reg(CFG_WIDTH, 0);
    write_reg(CFG_HEIGHT, 4095);
    push_pixel(0, 0, 9);
    push_pixel(5, 2047, 10);
    wait_drained();
    write_reg(CFG_WIDTH, 1);
    write_reg(CFG_HEIGHT, 1);
    write_reg(CFG_K1, 23'h400000);
    write_reg(CFG_K2, 22'h1FFFFF);
    push_pixel(0, 0, 11);
    push_pixel(1, 1, 12);
    wait_drained();
    write_reg(CFG_WIDTH, 2048);
    write_reg(CFG_HEIGHT, 2048);
    write_reg(CFG_K1, 23'd0);
    write_reg(CFG_K2, 22'd0);
    random_phase(300, 2048, 2048);
    write_reg(CFG_K1, $urandom_range(0, 2576980));
    write_reg(CFG_K2, -$urandom_range(0, 1288490));
    write_reg(CFG_WIDTH, 1920);
    write_reg(CFG_HEIGHT, 1080);
    random_phase(300, 1920, 1080);
    write_reg(CFG_K1, -$urandom_range(0, 2576980));
    write_reg(CFG_K2, $urandom_range(0, 1288490));
    write_reg(CFG_WIDTH, 17);
    write_reg(CFG_HEIGHT, 2047);
    random_phase(300, 17, 2047);
    write_reg(CFG_K1, $urandom());
    write_reg(CFG_K2, $urandom());
    write_reg(CFG_WIDTH, $urandom_range(1, 4095));
    write_reg(CFG_HEIGHT, $urandom_range(1, 4095));
    random_phase(250, img_w, img_h);
    write_reg(CFG_K1, 23'sd1000000);
    write_reg(CFG_K2, -22'sd500000);
    write_reg(CFG_WIDTH, 2048);
    write_reg(CFG_HEIGHT, 2048);
    random_phase(250, 2048, 2048);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule

FILE: sim.f
+incdir+rtl
rtl/rdpr_pkg.sv
rtl/rdpr_sqrt_cell.sv
rtl/radial_distortion_pixel_remap.sv
rtl/rdpr_checker.sv
tb/sv/radial_distortion_pixel_remap_test.sv
